@@ sv/tch_pkg.sv @@
// Shared constants and the arctangent table for the tilt-compensated height pipeline.
// No dependencies.
package tch_pkg;

  localparam int unsigned ANGLE_FRAC_BITS_DEF = 30;

  localparam int unsigned RANGE_W  = 16;
  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned HEIGHT_W = 22;

  localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 16'sd704;

  // angle reduction, 0.01 degree
  localparam int HALF_TURN = 18000;
  localparam int FULL_TURN = 36000;

  // pi in Q30 split as 36000*PI_WHOLE + PI_FRAC
  localparam int unsigned PI_WHOLE = 93701;
  localparam int unsigned PI_FRAC  = 23426;
  localparam int unsigned ZV_W     = 29;   // width of mag*PI_FRAC + HALF_TURN
  localparam int unsigned ZP_W     = 31;   // width of mag*PI_WHOLE and of |z|
  localparam int unsigned RECIP_W  = 30;
  localparam logic [RECIP_W-1:0] RECIP = 30'd977343670;  // ceil(2^45 / 36000)
  localparam int unsigned RECIP_SHIFT = 45;
  localparam int unsigned ZQ_W     = 14;   // quotient of v / 36000

  localparam int unsigned CORDIC_BITS  = 30;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CORDIC_W     = 34;
  localparam int unsigned CORDIC_ZW    = 33;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int unsigned QUOT_BITS = 22;

  // truncated Q30 arctangent of 2^-i
  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] r;
    unique case (i)
      0:  r = 30'd843314856;
      1:  r = 30'd497837829;
      2:  r = 30'd263043836;
      3:  r = 30'd133525158;
      4:  r = 30'd67021686;
      5:  r = 30'd33543515;
      6:  r = 30'd16775850;
      7:  r = 30'd8388437;
      8:  r = 30'd4194282;
      9:  r = 30'd2097149;
      10: r = 30'd1048575;
      11: r = 30'd524287;
      12: r = 30'd262143;
      13: r = 30'd131071;
      14: r = 30'd65535;
      15: r = 30'd32767;
      16: r = 30'd16383;
      17: r = 30'd8191;
      18: r = 30'd4095;
      19: r = 30'd2047;
      20: r = 30'd1023;
      21: r = 30'd511;
      22: r = 30'd255;
      23: r = 30'd127;
      24: r = 30'd63;
      25: r = 30'd31;
      26: r = 30'd15;
      27: r = 30'd8;
      28: r = 30'd4;
      29: r = 30'd2;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/tilt_compensated_height.sv @@
// Tilt-compensated height: angle scaling, CORDIC half-angle trig, quaternion
// products, projection and a bit-per-stage divider. Depends on tch_pkg.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------------
//  cfg      | cfg_valid_i / cfg_ready_o| mount_offset_y_i
//  in       | in_valid_i / in_stall_o  | range_cm_i, roll/pitch/yaw_angle_i
//  out      | out_valid_o / out_stall_i| true_height_o
//
// One item per cycle while in_stall_o is low. The pipeline has 66 stages (30 CORDIC
// iterations, 22 divider bits); a result then passes into the output register.
// Reset clears the valid bits, those of the output register and skid too; mount_offset_y returns to 704.
// The whole pipeline holds while the skid register is full, so in_stall_o is a flop and
// goes high in the cycle after a result arrives while a stall meets a full output register.
module tilt_compensated_height #(
  parameter int unsigned ANGLE_FRAC_BITS = tch_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic signed [tch_pkg::OFFSET_W-1:0]  mount_offset_y_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic        [tch_pkg::RANGE_W-1:0]   range_cm_i,
  input  logic signed [tch_pkg::ANGLE_W-1:0]   roll_angle_i,
  input  logic signed [tch_pkg::ANGLE_W-1:0]   pitch_angle_i,
  input  logic signed [tch_pkg::ANGLE_W-1:0]   yaw_angle_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [tch_pkg::HEIGHT_W-1:0]  true_height_o
);
  import tch_pkg::*;

  localparam int unsigned AF   = ANGLE_FRAC_BITS;
  localparam int unsigned TW   = AF + 3;          // trig, quaternion, a, b, n
  localparam int unsigned NUW  = TW - 1;          // positive norm
  localparam int unsigned NW   = TW + 22;         // numerator
  localparam int unsigned DW   = AF + 24;         // dividend / remainder
  localparam int unsigned RSH  = CORDIC_BITS - AF;
  localparam int unsigned QB   = QUOT_BITS;
  localparam int unsigned LANES = 3;              // roll, pitch, yaw

  localparam int unsigned ST_CORDIC = 3;
  localparam int unsigned ST_TRIG   = ST_CORDIC + CORDIC_STEPS + 1;
  localparam int unsigned ST_DIV    = ST_TRIG + 9;
  localparam int unsigned NSTG      = ST_DIV + QB + 1;
  localparam int unsigned RNG_N     = ST_TRIG + 6;

  localparam logic signed [2*TW-1:0] FM_HALF = (2*TW)'(1) << (AF - 1);
  localparam logic signed [TW-1:0]   N_ONE   = TW'(1) << AF;
  localparam logic [QB-1:0] Q_POS_MAX = QB'(2097151);
  localparam logic [QB-1:0] Q_NEG_MAX = QB'(2097152);
  localparam logic signed [HEIGHT_W-1:0] H_MAX = 22'sd2097151;
  localparam logic signed [HEIGHT_W-1:0] H_MIN = -22'sd2097152;

  function automatic logic signed [TW-1:0] fmul(input logic signed [TW-1:0] a,
                                                input logic signed [TW-1:0] b);
    logic signed [2*TW-1:0] p;
    p = a * b;
    p = p + FM_HALF;
    return TW'(p >>> AF);
  endfunction

  logic en;
  logic [NSTG-1:0] v_q;

  // configuration register
  logic signed [OFFSET_W-1:0] offset_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      offset_q <= mount_offset_y_i;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // range travels to the projection stage
  logic [RANGE_W-1:0] rng_q [RNG_N];
  always_ff @(posedge clk_i) begin
    if (en) begin
      rng_q[0] <= range_cm_i;
      for (int k = 1; k < RNG_N; k++) rng_q[k] <= rng_q[k-1];
    end
  end

  // ---------------- angle reduction ----------------
  logic signed [ANGLE_W-1:0] ang_in [LANES];
  assign ang_in[0] = roll_angle_i;
  assign ang_in[1] = pitch_angle_i;
  assign ang_in[2] = yaw_angle_i;

  logic [14:0] mag_d [LANES];
  logic [LANES-1:0] neg_d, flip_d;
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic signed [ANGLE_W:0] ext, red;
      ext = {ang_in[l][ANGLE_W-1], ang_in[l]};
      flip_d[l] = 1'b1;
      if (ext > HALF_TURN) begin
        red = (ANGLE_W+1)'(ext - FULL_TURN);
      end else if (ext < -HALF_TURN) begin
        red = (ANGLE_W+1)'(ext + FULL_TURN);
      end else begin
        red = ext;
        flip_d[l] = 1'b0;
      end
      neg_d[l] = red[ANGLE_W];
      mag_d[l] = red[ANGLE_W] ? 15'(-red) : 15'(red);
    end
  end

  logic [14:0] mag_q [LANES];
  logic [LANES-1:0] neg_q [ST_CORDIC];
  logic [LANES-1:0] fl_q [ST_TRIG];
  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q     <= mag_d;
      neg_q[0]  <= neg_d;
      fl_q[0]   <= flip_d;
      for (int k = 1; k < ST_CORDIC; k++) neg_q[k] <= neg_q[k-1];
      for (int k = 1; k < ST_TRIG; k++) fl_q[k] <= fl_q[k-1];
    end
  end

  // ---------------- half angle in Q30 ----------------
  logic [ZP_W-1:0] zp_q [LANES];
  logic [ZV_W-1:0] zv_q [LANES];
  logic [ZP_W-1:0] zm_q [LANES];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        zp_q[l] <= ZP_W'(mag_q[l]) * ZP_W'(PI_WHOLE);
        zv_q[l] <= ZV_W'(mag_q[l]) * ZV_W'(PI_FRAC) + ZV_W'(HALF_TURN);
      end
    end
  end

  // divide by 36000 through the reciprocal
  logic [ZV_W+RECIP_W-1:0] zr_d [LANES];
  always_comb begin
    for (int l = 0; l < LANES; l++) zr_d[l] = (ZV_W+RECIP_W)'(zv_q[l]) * RECIP;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        zm_q[l] <= zp_q[l] + ZP_W'(zr_d[l][RECIP_SHIFT +: ZQ_W]);
      end
    end
  end

  // ---------------- CORDIC rotator, one iteration per stage ----------------
  logic signed [CORDIC_W-1:0]  cx_q [CORDIC_STEPS+1][LANES];
  logic signed [CORDIC_W-1:0]  cy_q [CORDIC_STEPS+1][LANES];
  logic signed [CORDIC_ZW-1:0] cz_q [CORDIC_STEPS+1][LANES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        cx_q[0][l] <= CORDIC_GAIN;
        cy_q[0][l] <= '0;
        cz_q[0][l] <= neg_q[ST_CORDIC-1][l] ? -signed'(CORDIC_ZW'(zm_q[l]))
                                            :  signed'(CORDIC_ZW'(zm_q[l]));
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    localparam logic signed [CORDIC_ZW-1:0] ATAN = signed'(CORDIC_ZW'(atan_q30(k)));
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          if (cz_q[k][l] >= 0) begin
            cx_q[k+1][l] <= cx_q[k][l] - (cy_q[k][l] >>> k);
            cy_q[k+1][l] <= cy_q[k][l] + (cx_q[k][l] >>> k);
            cz_q[k+1][l] <= cz_q[k][l] - ATAN;
          end else begin
            cx_q[k+1][l] <= cx_q[k][l] + (cy_q[k][l] >>> k);
            cy_q[k+1][l] <= cy_q[k][l] - (cx_q[k][l] >>> k);
            cz_q[k+1][l] <= cz_q[k][l] + ATAN;
          end
        end
      end
    end
  end

  // ---------------- round to AF bits, undo the reduction ----------------
  logic signed [CORDIC_W-1:0] xr_d [LANES];
  logic signed [CORDIC_W-1:0] yr_d [LANES];
  if (RSH == 0) begin : g_rnd_none
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        xr_d[l] = cx_q[CORDIC_STEPS][l];
        yr_d[l] = cy_q[CORDIC_STEPS][l];
      end
    end
  end else begin : g_rnd
    localparam logic signed [CORDIC_W-1:0] RHALF = CORDIC_W'(1) << (RSH - 1);
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        xr_d[l] = (cx_q[CORDIC_STEPS][l] + RHALF) >>> RSH;
        yr_d[l] = (cy_q[CORDIC_STEPS][l] + RHALF) >>> RSH;
      end
    end
  end

  logic signed [TW-1:0] cs_q [LANES];
  logic signed [TW-1:0] sn_q [LANES];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        cs_q[l] <= fl_q[ST_TRIG-1][l] ? -TW'(xr_d[l]) : TW'(xr_d[l]);
        sn_q[l] <= fl_q[ST_TRIG-1][l] ? -TW'(yr_d[l]) : TW'(yr_d[l]);
      end
    end
  end

  // ---------------- quaternion ----------------
  logic signed [TW-1:0] ccp_q, ssp_q, scp_q, csp_q, cyw_q, syw_q;
  logic signed [TW-1:0] m_q [8];
  logic signed [TW-1:0] q_q [4];
  logic signed [TW-1:0] s00_q, s11_q, s22_q, s33_q, p01_q, p23_q;
  logic signed [TW-1:0] a_q, b_q;
  logic [NUW-1:0] n39_q;
  logic signed [TW-1:0] nsum_d;

  assign nsum_d = s00_q + s11_q + s22_q + s33_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ccp_q <= fmul(cs_q[0], cs_q[1]);
      ssp_q <= fmul(sn_q[0], sn_q[1]);
      scp_q <= fmul(sn_q[0], cs_q[1]);
      csp_q <= fmul(cs_q[0], sn_q[1]);
      cyw_q <= cs_q[2];
      syw_q <= sn_q[2];

      m_q[0] <= fmul(ccp_q, cyw_q);
      m_q[1] <= fmul(ssp_q, syw_q);
      m_q[2] <= fmul(scp_q, cyw_q);
      m_q[3] <= fmul(csp_q, syw_q);
      m_q[4] <= fmul(csp_q, cyw_q);
      m_q[5] <= fmul(scp_q, syw_q);
      m_q[6] <= fmul(ccp_q, syw_q);
      m_q[7] <= fmul(ssp_q, cyw_q);

      q_q[0] <= m_q[0] + m_q[1];
      q_q[1] <= m_q[2] - m_q[3];
      q_q[2] <= m_q[4] + m_q[5];
      q_q[3] <= m_q[6] - m_q[7];

      s00_q <= fmul(q_q[0], q_q[0]);
      s11_q <= fmul(q_q[1], q_q[1]);
      s22_q <= fmul(q_q[2], q_q[2]);
      s33_q <= fmul(q_q[3], q_q[3]);
      p01_q <= fmul(q_q[0], q_q[1]);
      p23_q <= fmul(q_q[2], q_q[3]);

      a_q   <= s00_q - s11_q - s22_q + s33_q;
      b_q   <= (p01_q + p23_q) <<< 1;
      n39_q <= (nsum_d <= 0) ? N_ONE[NUW-1:0] : nsum_d[NUW-1:0];
    end
  end

  // ---------------- projection on the down axis ----------------
  logic signed [20:0] r16_d;
  assign r16_d = signed'({1'b0, rng_q[RNG_N-1], 4'b0000});

  logic signed [NW-1:0] pr_q, po_q, num_q;
  logic [NUW-1:0] n40_q, n41_q, n42_q;
  logic [DW-1:0] dd_q;
  logic sg_q;
  logic signed [NW-1:0] nh_d;
  assign nh_d = signed'(NW'(n41_q >> 1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q  <= r16_d * a_q;
      po_q  <= offset_q * b_q;
      n40_q <= n39_q;

      num_q <= pr_q - po_q;
      n41_q <= n40_q;

      // |num| + n/2
      dd_q  <= num_q[NW-1] ? DW'(nh_d - num_q) : DW'(num_q + nh_d);
      sg_q  <= num_q[NW-1];
      n42_q <= n41_q;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic [DW-1:0]  dr_q  [QB+1];
  logic [QB-1:0]  dq_q  [QB+1];
  logic [NUW-1:0] dn_q  [QB+1];
  logic           dneg_q[QB+1];
  logic           dovf_q[QB+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dr_q[0]   <= dd_q;
      dq_q[0]   <= '0;
      dn_q[0]   <= n42_q;
      dneg_q[0] <= sg_q;
      dovf_q[0] <= (dd_q >= {n42_q, {QB{1'b0}}});
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int unsigned BIT = QB - 1 - j;
    logic [DW-1:0] sub_d;
    assign sub_d = DW'(dn_q[j]) << BIT;
    always_ff @(posedge clk_i) begin
      if (en) begin
        dn_q[j+1]   <= dn_q[j];
        dneg_q[j+1] <= dneg_q[j];
        dovf_q[j+1] <= dovf_q[j];
        if (dr_q[j] >= sub_d) begin
          dr_q[j+1] <= dr_q[j] - sub_d;
          dq_q[j+1] <= {dq_q[j][QB-2:0], 1'b1};
        end else begin
          dr_q[j+1] <= dr_q[j];
          dq_q[j+1] <= {dq_q[j][QB-2:0], 1'b0};
        end
      end
    end
  end

  // sign and saturation
  logic signed [HEIGHT_W-1:0] h_d;
  always_comb begin
    if (!dneg_q[QB]) begin
      h_d = (dovf_q[QB] || dq_q[QB] > Q_POS_MAX) ? H_MAX : signed'(HEIGHT_W'(dq_q[QB]));
    end else begin
      h_d = (dovf_q[QB] || dq_q[QB] > Q_NEG_MAX) ? H_MIN : -signed'(HEIGHT_W'(dq_q[QB]));
    end
  end

  // ---------------- output register and skid ----------------
  logic out_v_q, skid_v_q, push, out_rdy;
  logic signed [HEIGHT_W-1:0] height_q, skid_height_q;

  assign en         = ~skid_v_q;
  assign in_stall_o = skid_v_q;
  assign push       = v_q[NSTG-1] & en;
  assign out_rdy    = ~out_v_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_rdy) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      if (skid_v_q) begin
        height_q <= skid_height_q;
      end else if (push) begin
        height_q <= h_d;
      end
    end else if (push) begin
      skid_height_q <= h_d;
    end
  end

  assign out_valid_o   = out_v_q;
  assign true_height_o = height_q;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a transaction while the output register is empty");

  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_stall_i |=> skid_v_q)
    else $error("skid transaction dropped under stall");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> v_q == $past(v_q))
    else $error("pipeline moved while held");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NSTG-1] && !dovf_q[QB] |-> dr_q[QB] < DW'(dn_q[QB]))
    else $error("divider remainder not below divisor");

  a_norm_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[ST_DIV-4] |-> n39_q != '0)
    else $error("zero norm reached the divider");
`endif

endmodule
